/* hw/rtl/joystick_axis_calibrator_assert.svh */
// assertion helpers shared by the calibrator modules
`ifndef JOYSTICK_AXIS_CALIBRATOR_ASSERT_SVH
`define JOYSTICK_AXIS_CALIBRATOR_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define JAC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("joystick axis calibrator check failed");

// consequent checked in the cycle after the antecedent
`define JAC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("joystick axis calibrator check failed");

`endif

/* hw/rtl/jac_pkg.sv */
`default_nettype none

package jac_pkg;

    // field and datapath widths
    localparam int unsigned AXIS_W     = 2;
    localparam int unsigned CNT_W      = 16;
    localparam int unsigned HI_W       = CNT_W + 1;
    localparam int unsigned PROD_W     = 2 * CNT_W;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned POS_W      = 12;
    localparam int unsigned DVD_W      = HI_W + POS_W;
    localparam int unsigned STEP_W     = 5;
    localparam int unsigned NUM_AXES   = 4;
    localparam int unsigned LIMIT_W    = 48;
    localparam int unsigned TUNE_W     = 26;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned TDATA_W    = 16;
    localparam int unsigned TUSER_I_W  = 2;
    localparam int unsigned TUSER_O_W  = 4;

    // serial step counts
    localparam logic [STEP_W-1:0] MUL_STEPS  = 5'd16;
    localparam logic [STEP_W-1:0] DIV1_ITERS = 5'd16;
    localparam logic [STEP_W-1:0] DIV2_ITERS = 5'd12;

    // output scale
    localparam logic [POS_W-1:0] FULL_WIDE     = 12'd4095;
    localparam logic [POS_W-1:0] FULL_NARROW   = 12'd255;
    localparam logic [POS_W-1:0] CENTER_WIDE   = 12'd2047;
    localparam logic [POS_W-1:0] CENTER_NARROW = 12'd127;

    // register map
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_AXIS0_LIMITS = 3'd0,
        REG_AXIS1_LIMITS = 3'd1,
        REG_AXIS2_LIMITS = 3'd2,
        REG_AXIS3_LIMITS = 3'd3,
        REG_AXIS0_TUNING = 3'd4,
        REG_AXIS1_TUNING = 3'd5,
        REG_AXIS2_TUNING = 3'd6,
        REG_AXIS3_TUNING = 3'd7
    } t_reg_idx;

    // divider request
    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] iters;
    } t_div_ctl;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_JIT,
        ST_EDGE,
        ST_WIDTH,
        ST_SIDE,
        ST_MUL,
        ST_DIV1,
        ST_NUM,
        ST_SCALE,
        ST_DIV2,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

/* hw/rtl/jac_jitter.sv */
`default_nettype none

module jac_jitter #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic [jac_pkg::AXIS_W-1:0]  i_axis,
    input  logic [jac_pkg::CNT_W-1:0]   i_count,
    input  logic [jac_pkg::BYTE_W-1:0]  i_margin,
    input  logic [jac_pkg::BYTE_W-1:0]  i_resist,
    output logic [jac_pkg::CNT_W-1:0]   o_count,
    output logic                        o_held
);
    import jac_pkg::*;

    logic [CNT_W-1:0]  r_hold_pos [DEPTH];
    logic [BYTE_W-1:0] r_rep_cnt  [DEPTH];

    logic [CNT_W-1:0]  hp;
    logic [BYTE_W-1:0] rc;
    logic [CNT_W-1:0]  win_lo;
    logic [HI_W-1:0]   win_hi;
    logic              take;

    // pick the entry of this axis
    always_comb begin
        hp = '0;
        rc = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (i_axis == AXIS_W'(k)) begin
                hp = r_hold_pos[k];
                rc = r_rep_cnt[k];
            end
        end
    end

    // window test around the held count
    always_comb begin
        win_lo  = (hp > CNT_W'(i_margin)) ? hp - CNT_W'(i_margin) : '0;
        win_hi  = HI_W'(hp) + HI_W'(i_margin);
        take    = (i_count < win_lo) || (HI_W'(i_count) > win_hi) || (rc >= i_resist);
        o_held  = i_en && !take;
        o_count = o_held ? hp : i_count;
    end

    // per-axis hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_hold_pos[k] <= '0;
                r_rep_cnt[k]  <= '0;
            end
        end else if (i_en) begin
            for (int k = 0; k < DEPTH; k++) begin
                if (i_axis == AXIS_W'(k)) begin
                    if (take) begin
                        r_hold_pos[k] <= i_count;
                        r_rep_cnt[k]  <= '0;
                    end else begin
                        r_rep_cnt[k]  <= rc + 8'd1;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/jac_mul.sv */
`default_nettype none

`include "joystick_axis_calibrator_assert.svh"

module jac_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [jac_pkg::CNT_W-1:0]   i_mcand,
    input  logic [jac_pkg::CNT_W-1:0]   i_mplier,
    output logic                        o_done,
    output logic [jac_pkg::PROD_W-1:0]  o_product
);
    import jac_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [CNT_W-1:0]  r_mcand;
    logic [CNT_W-1:0]  r_hi;
    logic [CNT_W-1:0]  r_lo;
    logic [HI_W-1:0]   psum;

    // one multiplier bit a cycle, product shifts right
    assign psum = HI_W'(r_hi) + (r_lo[0] ? HI_W'(r_mcand) : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= MUL_STEPS;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // shift-add datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand <= i_mcand;
            r_hi    <= '0;
            r_lo    <= i_mplier;
        end else if (r_busy) begin
            r_hi <= psum[HI_W-1:1];
            r_lo <= {psum[0], r_lo[CNT_W-1:1]};
        end
    end

    assign o_done    = r_done;
    assign o_product = {r_hi, r_lo};

    `JAC_ASSERT_NOW(a_mul_no_restart, i_clk, i_rst_n, i_start, !r_busy)

endmodule

`default_nettype wire

/* hw/rtl/jac_div.sv */
`default_nettype none

`include "joystick_axis_calibrator_assert.svh"

module jac_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  jac_pkg::t_div_ctl          i_ctl,
    input  logic [jac_pkg::HI_W-1:0]   i_rem,
    input  logic [jac_pkg::CNT_W-1:0]  i_low,
    input  logic [jac_pkg::HI_W-1:0]   i_divisor,
    output logic                       o_done,
    output logic [jac_pkg::CNT_W-1:0]  o_quot
);
    import jac_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [HI_W-1:0]   r_rem;
    logic [HI_W-1:0]   r_d;
    logic [CNT_W-1:0]  r_q;
    logic [HI_W:0]     shifted;
    logic              ge;
    logic [HI_W:0]     diff;

    // restoring step: one quotient bit a cycle
    always_comb begin
        shifted = {r_rem, r_q[CNT_W-1]};
        ge      = shifted >= {1'b0, r_d};
        diff    = shifted - {1'b0, r_d};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_ctl.iters;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem <= i_rem;
            r_q   <= i_low;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[HI_W-1:0] : shifted[HI_W-1:0];
            r_q   <= {r_q[CNT_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

    `JAC_ASSERT_NOW(a_div_no_restart, i_clk, i_rst_n, i_ctl.start, !r_busy)
    `JAC_ASSERT_NEXT(a_div_done_pulse, i_clk, i_rst_n, r_done, !r_done)

endmodule

`default_nettype wire

/* hw/rtl/joystick_axis_calibrator.sv */
// channel   dir  tdata                       tuser
// s_axis    in   [15:0] raw_count            [1:0] axis_index
// m_axis    out  [11:0] position, [15:12] 0  [1:0] axis_out, [2] held, [3] centered
// cfg       in   write enable, 3-bit register index, 48-bit data, no read-back
//
// one word is in the sequencer at a time; its path is shortest for an uncalibrated word,
// then longer in the dead zone, for a zero side width, without side scaling and with it;
// the bit-serial 16x16 multiplier and the shared divider do the longest steps, and the
// divider runs 16 quotient bits for side scaling and 12 for the output scale
// synchronous active-low reset clears config, per-axis hold state and handshakes
// a finished word waits in the output register; the next word is taken meanwhile,
// and a word that finishes while that register is still full stalls until it drains

`default_nettype none

`include "joystick_axis_calibrator_assert.svh"

module joystick_axis_calibrator #(
    parameter int unsigned AXIS_COUNT = 4,
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [jac_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [jac_pkg::LIMIT_W-1:0]     i_cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [jac_pkg::TDATA_W-1:0]     s_axis_tdata,   // [15:0] raw_count
    input  logic [jac_pkg::TUSER_I_W-1:0]   s_axis_tuser,   // [1:0] axis_index
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [jac_pkg::TDATA_W-1:0]     m_axis_tdata,   // [11:0] position
    output logic [jac_pkg::TUSER_O_W-1:0]   m_axis_tuser    // [1:0] axis_out, [2] held,
                                                            // [3] centered
);
    import jac_pkg::*;

    localparam int unsigned ST_DEPTH = (AXIS_COUNT < NUM_AXES) ? AXIS_COUNT : NUM_AXES;
    localparam int unsigned P_BITS   = (COUNT_BITS < CNT_W) ? COUNT_BITS : CNT_W;
    localparam logic [CNT_W-1:0] P_MASK = CNT_W'((64'd1 << P_BITS) - 64'd1);

    // configuration registers
    logic [LIMIT_W-1:0] r_limits [NUM_AXES];
    logic [TUNE_W-1:0]  r_tuning [NUM_AXES];

    t_state r_state;
    t_state n_state;

    // per-word working registers
    logic [AXIS_W-1:0] r_axis;
    logic [CNT_W-1:0]  r_p;
    logic              r_held;
    logic              r_centered;
    logic              r_wide;
    logic              r_oor;
    logic              r_cal;
    logic              r_anti;
    logic [CNT_W-1:0]  r_mn;
    logic [CNT_W-1:0]  r_ct;
    logic [CNT_W-1:0]  r_mx;
    logic [BYTE_W-1:0] r_dz;
    logic [BYTE_W-1:0] r_margin;
    logic [BYTE_W-1:0] r_resist;
    logic [CNT_W-1:0]  r_lo;
    logic [HI_W-1:0]   r_hi;
    logic [CNT_W-1:0]  r_w1;
    logic [CNT_W-1:0]  r_w2;
    logic [CNT_W-1:0]  r_pc;
    logic              r_low_side;
    logic [CNT_W-1:0]  r_w;
    logic [CNT_W-1:0]  r_wbig;
    logic [CNT_W-1:0]  r_v;
    logic [HI_W-1:0]   r_num;
    logic [POS_W-1:0]  r_pos;

    // output register
    logic              r_out_valid;
    logic [AXIS_W-1:0] r_out_axis;
    logic [POS_W-1:0]  r_out_pos;
    logic              r_out_held;
    logic              r_out_cent;

    // handshake and unit control
    logic     accept;
    logic     load_out;
    logic     jit_en;
    logic     mul_start;
    t_div_ctl div_ctl;

    // unit results
    logic [CNT_W-1:0]  jit_count;
    logic              jit_held;
    logic              mul_done;
    logic [PROD_W-1:0] mul_prod;
    logic              div_done;
    logic [CNT_W-1:0]  div_quot;
    logic [HI_W-1:0]   div_rem;
    logic [CNT_W-1:0]  div_low;
    logic [HI_W-1:0]   div_divisor;

    // combinational datapath
    logic [LIMIT_W-1:0] sel_limits;
    logic [TUNE_W-1:0]  sel_tuning;
    logic [POS_W-1:0]   full;
    logic [POS_W-1:0]   center;
    logic [CNT_W-1:0]   lo_calc;
    logic [HI_W-1:0]    hi_calc;
    logic [CNT_W-1:0]   w1_calc;
    logic [CNT_W-1:0]   w2_calc;
    logic [CNT_W-1:0]   pc_calc;
    logic               in_dz;
    logic [CNT_W-1:0]   w_calc;
    logic [CNT_W-1:0]   wbig_calc;
    logic               low_calc;
    logic [CNT_W-1:0]   v_calc;
    logic               scale_calc;
    logic [HI_W-1:0]    num_calc;
    logic [DVD_W-1:0]   dvd_calc;
    logic               over;
    logic [POS_W-1:0]   q_pos;

    // config write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                r_limits[k] <= '0;
                r_tuning[k] <= '0;
            end
        end else if (i_cfg_wr_en) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_AXIS0_LIMITS: r_limits[0] <= i_cfg_wdata;
                REG_AXIS1_LIMITS: r_limits[1] <= i_cfg_wdata;
                REG_AXIS2_LIMITS: r_limits[2] <= i_cfg_wdata;
                REG_AXIS3_LIMITS: r_limits[3] <= i_cfg_wdata;
                REG_AXIS0_TUNING: r_tuning[0] <= i_cfg_wdata[TUNE_W-1:0];
                REG_AXIS1_TUNING: r_tuning[1] <= i_cfg_wdata[TUNE_W-1:0];
                REG_AXIS2_TUNING: r_tuning[2] <= i_cfg_wdata[TUNE_W-1:0];
                REG_AXIS3_TUNING: r_tuning[3] <= i_cfg_wdata[TUNE_W-1:0];
            endcase
        end
    end

    // anti-jitter hold state
    jac_jitter #(
        .DEPTH (ST_DEPTH)
    ) u_jitter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (jit_en),
        .i_axis   (r_axis),
        .i_count  (r_p),
        .i_margin (r_margin),
        .i_resist (r_resist),
        .o_count  (jit_count),
        .o_held   (jit_held)
    );

    // bit-serial side scaling multiplier
    jac_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_mcand   (v_calc),
        .i_mplier  (w_calc),
        .o_done    (mul_done),
        .o_product (mul_prod)
    );

    // shared serial divider
    jac_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (div_ctl),
        .i_rem     (div_rem),
        .i_low     (div_low),
        .i_divisor (div_divisor),
        .o_done    (div_done),
        .o_quot    (div_quot)
    );

    // arithmetic for each sequencer step
    always_comb begin
        sel_limits = r_limits[s_axis_tuser];
        sel_tuning = r_tuning[s_axis_tuser];
        full       = r_wide ? FULL_WIDE : FULL_NARROW;
        center     = r_wide ? CENTER_WIDE : CENTER_NARROW;

        // dead zone edges
        lo_calc = (r_ct > CNT_W'(r_dz)) ? r_ct - CNT_W'(r_dz) : '0;
        hi_calc = HI_W'(r_ct) + HI_W'(r_dz);

        // side widths, clamp, dead zone test
        w1_calc = (r_lo > r_mn) ? r_lo - r_mn : '0;
        w2_calc = (HI_W'(r_mx) > r_hi) ? CNT_W'(HI_W'(r_mx) - r_hi) : '0;
        if (r_p < r_mn) begin
            pc_calc = r_mn;
        end else if (r_p > r_mx) begin
            pc_calc = r_mx;
        end else begin
            pc_calc = r_p;
        end
        in_dz = (r_p == '0) || ((r_p >= r_lo) && (HI_W'(r_p) <= r_hi));

        // side offset and scaling choice
        w_calc    = (r_w1 < r_w2) ? r_w1 : r_w2;
        wbig_calc = (r_w1 > r_w2) ? r_w1 : r_w2;
        low_calc  = r_pc < r_ct;
        if (low_calc) begin
            v_calc     = (r_lo > r_pc) ? r_lo - r_pc : '0;
            scale_calc = r_w1 > r_w2;
        end else begin
            v_calc     = (HI_W'(r_pc) > r_hi) ? CNT_W'(HI_W'(r_pc) - r_hi) : '0;
            scale_calc = r_w2 > r_w1;
        end

        // numerator over 2w
        if (r_low_side) begin
            num_calc = (r_w > r_v) ? HI_W'(r_w - r_v) : '0;
        end else begin
            num_calc = HI_W'(r_w) + HI_W'(r_v);
        end

        // times full scale by shift and subtract
        if (r_wide) begin
            dvd_calc = {r_num, POS_W'(0)} - DVD_W'(r_num);
        end else begin
            dvd_calc = DVD_W'({r_num, BYTE_W'(0)}) - DVD_W'(r_num);
        end
        over = r_num > {r_w, 1'b0};

        // final quotient, clamped
        q_pos = (div_quot[POS_W-1:0] > full) ? full : div_quot[POS_W-1:0];

        // divider operands: side scaling or output scaling
        if (r_state == ST_MUL) begin
            div_rem     = {1'b0, mul_prod[PROD_W-1:CNT_W]};
            div_low     = mul_prod[CNT_W-1:0];
            div_divisor = {1'b0, r_wbig};
        end else begin
            div_rem     = dvd_calc[DVD_W-1:POS_W];
            div_low     = {dvd_calc[POS_W-1:0], (CNT_W - POS_W)'(0)};
            div_divisor = {r_w, 1'b0};
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        jit_en        = 1'b0;
        mul_start     = 1'b0;
        div_ctl       = '{start: 1'b0, iters: DIV2_ITERS};
        load_out      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = ST_JIT;
                end
            end
            ST_JIT: begin
                jit_en  = r_anti && !r_oor;
                n_state = (r_oor || !r_cal) ? ST_OUT : ST_EDGE;
            end
            ST_EDGE: begin
                n_state = ST_WIDTH;
            end
            ST_WIDTH: begin
                n_state = in_dz ? ST_OUT : ST_SIDE;
            end
            ST_SIDE: begin
                priority if (w_calc == '0) begin
                    n_state = ST_OUT;
                end else if (scale_calc) begin
                    mul_start = 1'b1;
                    n_state   = ST_MUL;
                end else begin
                    n_state = ST_NUM;
                end
            end
            ST_MUL: begin
                if (mul_done) begin
                    div_ctl = '{start: 1'b1, iters: DIV1_ITERS};
                    n_state = ST_DIV1;
                end
            end
            ST_DIV1: begin
                if (div_done) begin
                    n_state = ST_NUM;
                end
            end
            ST_NUM: begin
                n_state = ST_SCALE;
            end
            ST_SCALE: begin
                if (over) begin
                    n_state = ST_OUT;
                end else begin
                    div_ctl = '{start: 1'b1, iters: DIV2_ITERS};
                    n_state = ST_DIV2;
                end
            end
            ST_DIV2: begin
                if (div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign accept = s_axis_tvalid && s_axis_tready;

    // working registers, loaded per step
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_axis   <= s_axis_tuser;
            r_p      <= s_axis_tdata & P_MASK;
            r_wide   <= !s_axis_tuser[1];
            r_oor    <= 32'(s_axis_tuser) >= AXIS_COUNT;
            r_mn     <= sel_limits[CNT_W-1:0];
            r_ct     <= sel_limits[2*CNT_W-1:CNT_W];
            r_mx     <= sel_limits[3*CNT_W-1:2*CNT_W];
            r_dz     <= sel_tuning[BYTE_W-1:0];
            r_margin <= sel_tuning[2*BYTE_W-1:BYTE_W];
            r_resist <= sel_tuning[3*BYTE_W-1:2*BYTE_W];
            r_cal    <= sel_tuning[3*BYTE_W];
            r_anti   <= sel_tuning[3*BYTE_W+1];
        end
        unique case (r_state)
            ST_JIT: begin
                r_p        <= jit_count;
                r_held     <= jit_held;
                r_centered <= 1'b1;
                r_pos      <= center;
            end
            ST_EDGE: begin
                r_lo <= lo_calc;
                r_hi <= hi_calc;
            end
            ST_WIDTH: begin
                r_w1 <= w1_calc;
                r_w2 <= w2_calc;
                r_pc <= pc_calc;
            end
            ST_SIDE: begin
                r_w        <= w_calc;
                r_wbig     <= wbig_calc;
                r_low_side <= low_calc;
                r_v        <= v_calc;
                if (w_calc != '0) begin
                    r_centered <= 1'b0;
                end
            end
            ST_DIV1: begin
                if (div_done) begin
                    r_v <= div_quot;
                end
            end
            ST_NUM: begin
                r_num <= num_calc;
            end
            ST_SCALE: begin
                if (over) begin
                    r_pos <= full;
                end
            end
            ST_DIV2: begin
                if (div_done) begin
                    r_pos <= q_pos;
                end
            end
            default: begin
            end
        endcase
        if (load_out) begin
            r_out_axis <= r_axis;
            r_out_pos  <= r_pos;
            r_out_held <= r_held;
            r_out_cent <= r_centered;
        end
    end

    // result word
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TDATA_W'(r_out_pos);
    assign m_axis_tuser  = {r_out_cent, r_out_held, r_out_axis};

    `JAC_ASSERT_NOW(a_out_from_final, i_clk, i_rst_n, $rose(m_axis_tvalid),
                    $past(r_state) == ST_OUT)
    `JAC_ASSERT_NOW(a_center_value, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[3],
                    m_axis_tdata[POS_W-1:0] == (m_axis_tuser[1] ? CENTER_NARROW : CENTER_WIDE))
    `JAC_ASSERT_NOW(a_narrow_range, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[1],
                    m_axis_tdata[POS_W-1:BYTE_W] == '0)

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
module tb;
    import jac_pkg::*;

    // one expected output word
    typedef struct packed {
        logic [AXIS_W-1:0] axis;
        logic [POS_W-1:0]  position;
        logic              held;
        logic              centered;
    } t_axis_result;

    typedef enum {CFG_ALL_ONES, CFG_ALL_ZEROS, CFG_SHAPED, CFG_RAW} t_cfg_style;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [LIMIT_W-1:0]    i_cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [TDATA_W-1:0]    s_axis_tdata;    // [15:0] raw_count
    logic [TUSER_I_W-1:0]  s_axis_tuser;    // [1:0] axis_index
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [TDATA_W-1:0]    m_axis_tdata;    // [11:0] position, [15:12] zero
    logic [TUSER_O_W-1:0]  m_axis_tuser;    // [1:0] axis_out, [2] held, [3] centered

    // shadow register file and per-axis hold state
    logic [LIMIT_W-1:0] axis_limits_q [NUM_AXES];
    logic [TUNE_W-1:0]  axis_tuning_q [NUM_AXES];
    logic [CNT_W-1:0]   hold_count    [NUM_AXES];
    logic [BYTE_W-1:0]  hold_streak   [NUM_AXES];

    t_axis_result expected_positions [$];

    bit calm;
    int errors;
    int samples_sent;
    int held_seen;
    int centered_seen;
    int settings_used;

    joystick_axis_calibrator #(
        .AXIS_COUNT(NUM_AXES),
        .COUNT_BITS(CNT_W)
    ) u_top (.*);

    // clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // expected word for one sample, updates the hold state
    function automatic t_axis_result predict_position(input logic [AXIS_W-1:0] ax,
                                                      input logic [CNT_W-1:0] raw);
        bit [63:0]    p, mn, ct, mx, dz, margin, resist, win_lo, win_hi;
        bit [63:0]    edge_lo, edge_hi, w_lo, w_hi, w, v, num, full, pos;
        bit           wide, cal, anti;
        t_axis_result r;
        wide   = (ax < 2);
        full   = wide ? FULL_WIDE : FULL_NARROW;
        p      = raw;
        mn     = axis_limits_q[ax][15:0];
        ct     = axis_limits_q[ax][31:16];
        mx     = axis_limits_q[ax][47:32];
        dz     = axis_tuning_q[ax][7:0];
        margin = axis_tuning_q[ax][15:8];
        resist = axis_tuning_q[ax][23:16];
        cal    = axis_tuning_q[ax][24];
        anti   = axis_tuning_q[ax][25];
        r.axis     = ax;
        r.held     = 1'b0;
        r.centered = 1'b1;
        r.position = wide ? CENTER_WIDE : CENTER_NARROW;

        // anti-jitter window around the held count
        if (anti) begin
            win_lo = (hold_count[ax] > margin) ? hold_count[ax] - margin : 0;
            win_hi = hold_count[ax] + margin;
            if (p < win_lo || p > win_hi || hold_streak[ax] >= resist) begin
                hold_streak[ax] = '0;
                hold_count[ax]  = raw;
            end else begin
                hold_streak[ax] = hold_streak[ax] + 1'b1;
                p               = hold_count[ax];
                r.held          = 1'b1;
            end
        end

        // dead zone, clamp, side scaling and output scale
        if (cal) begin
            edge_lo = (ct > dz) ? ct - dz : 0;
            edge_hi = ct + dz;
            w_lo    = (edge_lo > mn) ? edge_lo - mn : 0;
            w_hi    = (mx > edge_hi) ? mx - edge_hi : 0;
            w       = (w_lo < w_hi) ? w_lo : w_hi;
            if (!(p == 0 || (p >= edge_lo && p <= edge_hi) || w == 0)) begin
                if (p < mn)
                    p = mn;
                else if (p > mx)
                    p = mx;
                if (p < ct) begin
                    v = (edge_lo > p) ? edge_lo - p : 0;
                    if (w_lo > w_hi)
                        v = (v * w_hi) / w_lo;
                    num = (w > v) ? w - v : 0;
                end else begin
                    v = (p > edge_hi) ? p - edge_hi : 0;
                    if (w_hi > w_lo)
                        v = (v * w_lo) / w_hi;
                    num = w + v;
                end
                pos = (num * full) / (2 * w);
                if (pos > full)
                    pos = full;
                r.position = pos[POS_W-1:0];
                r.centered = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic logic [LIMIT_W-1:0] limits_word(input logic [CNT_W-1:0] mn, ct, mx);
        return {mx, ct, mn};
    endfunction

    function automatic logic [TUNE_W-1:0] tuning_word(input logic [BYTE_W-1:0] dz, margin,
                                                      input logic [BYTE_W-1:0] resist,
                                                      input logic cal, anti);
        return {anti, cal, resist, margin, dz};
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    // raw count biased toward the hold window and the calibration range
    function automatic logic [CNT_W-1:0] pick_raw(input logic [AXIS_W-1:0] ax);
        int lo, hi, pick;
        lo = int'(axis_limits_q[ax][15:0]);
        hi = int'(axis_limits_q[ax][47:32]);
        case ($urandom_range(9))
            0, 1, 2, 3: pick = int'(hold_count[ax]) + int'($urandom_range(80)) - 40;
            4, 5:       pick = int'($urandom_range(lo, hi)) + int'($urandom_range(100)) - 50;
            6: begin
                case ($urandom_range(4))
                    0:       pick = 0;
                    1:       pick = 65535;
                    2:       pick = lo;
                    3:       pick = hi;
                    default: pick = int'(axis_limits_q[ax][31:16]);
                endcase
            end
            default:    pick = int'($urandom_range(65535));
        endcase
        if (pick < 0)
            pick = 0;
        else if (pick > 65535)
            pick = 65535;
        return 16'(pick);
    endfunction

    // one sample word onto the input stream
    task automatic send_sample(input logic [AXIS_W-1:0] ax, input logic [CNT_W-1:0] raw);
        int gap;
        gap = (!calm && $urandom_range(99) < 20) ? int'($urandom_range(1, 12)) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= raw;
        s_axis_tuser  <= ax;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_positions.push_back(predict_position(ax, raw));
        samples_sent++;
    endtask

    // wait until every sent word has come back
    task automatic drain_results;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_positions.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [LIMIT_W-1:0] value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx < REG_AXIS0_TUNING)
            axis_limits_q[idx - REG_AXIS0_LIMITS] = value;
        else
            axis_tuning_q[idx - REG_AXIS0_TUNING] = value[TUNE_W-1:0];
    endtask

    task automatic set_axis(input int ax, input logic [LIMIT_W-1:0] lim,
                            input logic [TUNE_W-1:0] tun);
        write_reg(t_reg_idx'(REG_AXIS0_LIMITS + ax), lim);
        write_reg(t_reg_idx'(REG_AXIS0_TUNING + ax), {{(LIMIT_W-TUNE_W){1'b0}}, tun});
    endtask

    // one register set per axis in the given style
    task automatic configure_axes(input t_cfg_style style);
        logic [CNT_W-1:0]   mn, ct, mx;
        logic [LIMIT_W-1:0] lim;
        logic [TUNE_W-1:0]  tun;
        for (int k = 0; k < NUM_AXES; k++) begin
            mn  = 16'($urandom_range(20000));
            ct  = mn + 16'($urandom_range(20000));
            mx  = ct + 16'($urandom_range(25000));
            lim = limits_word(mn, ct, mx);
            tun = tuning_word(8'($urandom_range(255)),
                              ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom_range(40)),
                              ($urandom_range(7) == 0) ? 8'hFF : 8'($urandom_range(6)),
                              $urandom_range(9) != 0, $urandom_range(9) < 6);
            case (style)
                CFG_ALL_ONES: begin
                    lim = '1;
                    tun = '1;
                end
                CFG_ALL_ZEROS: begin
                    lim = '0;
                    tun = tuning_word('0, '0, '0, 1'b1, 1'b1);
                end
                CFG_RAW: begin
                    lim = LIMIT_W'({$urandom, $urandom});
                    tun = TUNE_W'($urandom);
                end
                default: begin
                    if ($urandom_range(4) == 0)
                        lim = LIMIT_W'({$urandom, $urandom});
                end
            endcase
            set_axis(k, lim, tun);
        end
        settings_used++;
    endtask

    // registers at reset: every axis gives its center value
    task automatic test_uncalibrated;
        send_sample(2'd0, 16'hFFFF);
        send_sample(2'd1, 16'h0000);
        send_sample(2'd2, 16'd1234);
        send_sample(2'd3, 16'hFFFF);
        drain_results();
    endtask

    // dead zone edges, clamping, asymmetric sides, zero width, saturated low edge
    task automatic test_calibration;
        set_axis(0, limits_word(16'd1000, 16'd30000, 16'd60000),
                 tuning_word(8'd200, 8'd0, 8'd0, 1'b1, 1'b0));
        set_axis(1, limits_word(16'd0, 16'd100, 16'hFFFF),
                 tuning_word(8'd255, 8'd0, 8'd0, 1'b1, 1'b0));
        set_axis(2, limits_word(16'd100, 16'd5000, 16'd7000),
                 tuning_word(8'd0, 8'd0, 8'd0, 1'b1, 1'b0));
        set_axis(3, limits_word(16'd0, 16'd0, 16'd0),
                 tuning_word(8'd0, 8'd10, 8'd2, 1'b0, 1'b1));
        send_sample(2'd0, 16'd0);
        send_sample(2'd0, 16'd999);
        send_sample(2'd0, 16'd1000);
        send_sample(2'd0, 16'd29800);
        send_sample(2'd0, 16'd30200);
        send_sample(2'd0, 16'd30201);
        send_sample(2'd0, 16'd60000);
        send_sample(2'd0, 16'hFFFF);
        send_sample(2'd1, 16'd5000);
        send_sample(2'd2, 16'd100);
        send_sample(2'd2, 16'd3000);
        send_sample(2'd2, 16'd5000);
        send_sample(2'd2, 16'd6999);
        send_sample(2'd2, 16'hFFFF);
        drain_results();
    endtask

    // hold inside the margin, resistance reached, window leaving, window at zero
    task automatic test_jitter_hold;
        set_axis(2, limits_word(16'd100, 16'd5000, 16'd7000),
                 tuning_word(8'd0, 8'd5, 8'd2, 1'b1, 1'b1));
        send_sample(2'd2, 16'd3);
        send_sample(2'd2, 16'd4);
        send_sample(2'd2, 16'd2);
        send_sample(2'd2, 16'd3000);
        send_sample(2'd2, 16'd3004);
        send_sample(2'd2, 16'd2995);
        send_sample(2'd2, 16'd3001);
        // uncalibrated axis still runs the hold
        send_sample(2'd3, 16'd0);
        send_sample(2'd3, 16'd50);
        send_sample(2'd3, 16'd55);
        drain_results();
    endtask

    // random register sets, one quiet phase without idling
    task automatic test_random;
        t_cfg_style       style;
        logic [AXIS_W-1:0] ax;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0:       style = CFG_ALL_ONES;
                1:       style = CFG_ALL_ZEROS;
                5:       style = CFG_RAW;
                default: style = CFG_SHAPED;
            endcase
            calm = (ph == 3);
            configure_axes(style);
            repeat (130) begin
                ax = 2'($urandom_range(3));
                send_sample(ax, pick_raw(ax));
            end
            drain_results();
        end
        calm = 1'b0;
    endtask

    // output side: random stalls
    always @(negedge i_clk)
        m_axis_tready <= calm || ($urandom_range(99) >= 20);

    // compare every output word with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_axis_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_positions.size() == 0) begin
                errors++;
                $display("%0t: unexpected word, expected none, actual tdata %h tuser %h",
                         $time, m_axis_tdata, m_axis_tuser);
            end else begin
                want = expected_positions.pop_front();
                check_field("axis_out", want.axis, m_axis_tuser[1:0]);
                check_field("position", want.position, m_axis_tdata[11:0]);
                check_field("tdata padding", '0, m_axis_tdata[15:12]);
                check_field("held", want.held, m_axis_tuser[2]);
                check_field("centered", want.centered, m_axis_tuser[3]);
                held_seen     += want.held;
                centered_seen += want.centered;
            end
        end
    end

    // run limit
    initial begin
        #5_000_000;
        $display("joystick_axis_calibrator verification failed");
        $finish;
    end

    // test sequence
    initial begin
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_addr    = REG_AXIS0_LIMITS;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        calm          = 1'b0;
        errors        = 0;
        samples_sent  = 0;
        held_seen     = 0;
        centered_seen = 0;
        settings_used = 0;
        foreach (axis_limits_q[k]) begin
            axis_limits_q[k] = '0;
            axis_tuning_q[k] = '0;
            hold_count[k]    = '0;
            hold_streak[k]   = '0;
        end
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_uncalibrated();
        test_calibration();
        test_jitter_hold();
        test_random();

        // catch any stray word after the last one
        repeat (80) @(posedge i_clk);
        $display("%0d samples checked over %0d random register sets and the directed ones",
                 samples_sent, settings_used);
        $display("%0d words came back held and %0d centered", held_seen, centered_seen);
        if (errors == 0)
            $display("joystick_axis_calibrator verification clean");
        else
            $display("joystick_axis_calibrator verification failed");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/jac_pkg.sv
hw/rtl/jac_jitter.sv
hw/rtl/jac_mul.sv
hw/rtl/jac_div.sv
hw/rtl/joystick_axis_calibrator.sv
tb/sv/tb.sv
